### hdl/twrle_pkg.sv
// shared types, constants and run emission function for the word run-length encoder
package twrle_pkg;

    localparam int WORD_W      = 16;
    localparam int RUN_WORDS   = 3;
    localparam int GROUP_DEPTH = 2 * RUN_WORDS;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t RUN_MAX       = '1;
    localparam word_t LITERAL_LIMIT = word_t'(3);

    typedef struct packed {
        word_t [RUN_WORDS-1:0] words;
        logic  [1:0]           n;
    } run_emit_t;

    // words for one closed run: a tag, count, value triple or up to three literals
    function automatic run_emit_t emit_run(word_t value, word_t count, word_t tag);
        run_emit_t r;
        r.words[0] = value;
        r.words[1] = value;
        r.words[2] = value;
        r.n        = count[1:0];
        if (count > LITERAL_LIMIT || value == tag) begin
            r.words[0] = tag;
            r.words[1] = count;
            r.words[2] = value;
            r.n        = 2'd3;
        end
        return r;
    endfunction

endpackage

### hdl/tagged_word_run_length_encoder.sv
// Word run-length encoder with an escape tag. Each input request is folded into the
// pending run in the cycle it is accepted; the zero to six output words it releases
// (a closed run plus, on tlast, the final run) are loaded into a six-word group
// register that shifts one word a cycle into a two-entry output queue while it has room. A
// new input request is taken every cycle as long as the previous one released at most one
// word and the queue has room for it; a request that releases more words holds s_tready low
// while the group register drains. The escape tag is sampled when a run is closed.
module tagged_word_run_length_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,    // escape_tag
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // word_in
    input  logic        s_tlast,      // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // word_out
    output logic        m_tlast       // end_of_block
);

    twrle_pkg::word_t tag_reg;
    twrle_pkg::word_t run_value_reg;
    twrle_pkg::word_t run_length_reg;
    logic             run_open_reg;

    twrle_pkg::word_t grp_word_reg [twrle_pkg::GROUP_DEPTH];
    logic [2:0]       grp_cnt_reg;
    logic             grp_last_reg;

    twrle_pkg::word_t fifo_data_reg [2];
    logic             fifo_last_reg [2];
    logic [1:0]       fifo_cnt_reg;

    logic                 s_accept;
    logic                 grp_push;
    logic                 m_pop;
    logic                 run_cont;
    twrle_pkg::word_t     new_value;
    twrle_pkg::word_t     new_length;
    twrle_pkg::run_emit_t close_em;
    twrle_pkg::run_emit_t last_em;
    twrle_pkg::word_t     merged_word [twrle_pkg::GROUP_DEPTH];
    logic [2:0]           merged_cnt;
    logic [2:0]           merged_idx;
    logic                 fifo_wpos;

    assign s_accept = s_tvalid && s_tready;
    assign grp_push = (grp_cnt_reg != 3'd0) && (fifo_cnt_reg < 2'd2);
    assign m_pop    = m_tvalid && m_tready;
    assign s_tready = (grp_cnt_reg == 3'd0) || ((grp_cnt_reg == 3'd1) && (fifo_cnt_reg < 2'd2));
    assign m_tvalid = fifo_cnt_reg != 2'd0;
    assign m_tdata  = fifo_data_reg[0];
    assign m_tlast  = fifo_last_reg[0];

    // run tracking and word generation
    always_comb begin
        run_cont   = run_open_reg && (s_tdata == run_value_reg)
                     && (run_length_reg != twrle_pkg::RUN_MAX);
        close_em   = twrle_pkg::emit_run(run_value_reg, run_length_reg, tag_reg);
        if (!run_open_reg || run_cont) begin
            close_em.n = 2'd0;
        end
        new_value  = run_cont ? run_value_reg : s_tdata;
        new_length = run_cont ? run_length_reg + twrle_pkg::word_t'(1) : twrle_pkg::word_t'(1);
        last_em    = twrle_pkg::emit_run(new_value, new_length, tag_reg);
        if (!s_tlast) begin
            last_em.n = 2'd0;
        end
        for (int i = 0; i < twrle_pkg::GROUP_DEPTH; i++) begin
            merged_word[i] = '0;
        end
        for (int i = 0; i < twrle_pkg::RUN_WORDS; i++) begin
            merged_word[i] = close_em.words[i];
        end
        for (int j = 0; j < twrle_pkg::RUN_WORDS; j++) begin
            merged_idx = 3'(j) + {1'b0, close_em.n};
            merged_word[merged_idx] = last_em.words[j];
        end
        merged_cnt = {1'b0, close_em.n} + {1'b0, last_em.n};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (cfg_we) begin
            tag_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_value_reg  <= '0;
            run_length_reg <= '0;
            run_open_reg   <= 1'b0;
        end else if (s_accept) begin
            if (s_tlast) begin
                run_value_reg  <= '0;
                run_length_reg <= '0;
                run_open_reg   <= 1'b0;
            end else begin
                run_value_reg  <= new_value;
                run_length_reg <= new_length;
                run_open_reg   <= 1'b1;
            end
        end
    end

    // group register: loaded on accept, shifts one word per push
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_cnt_reg <= 3'd0;
        end else if (s_accept) begin
            grp_cnt_reg <= merged_cnt;
        end else if (grp_push) begin
            grp_cnt_reg <= grp_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            grp_last_reg <= s_tlast;
            for (int i = 0; i < twrle_pkg::GROUP_DEPTH; i++) begin
                grp_word_reg[i] <= merged_word[i];
            end
        end else if (grp_push) begin
            for (int i = 0; i < twrle_pkg::GROUP_DEPTH - 1; i++) begin
                grp_word_reg[i] <= grp_word_reg[i+1];
            end
        end
    end

    // two-entry output queue
    assign fifo_wpos = fifo_cnt_reg[0] && !m_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_cnt_reg <= 2'd0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_reg + {1'b0, grp_push} - {1'b0, m_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_push && !fifo_wpos) begin
            fifo_data_reg[0] <= grp_word_reg[0];
            fifo_last_reg[0] <= grp_last_reg && (grp_cnt_reg == 3'd1);
        end else if (m_pop) begin
            fifo_data_reg[0] <= fifo_data_reg[1];
            fifo_last_reg[0] <= fifo_last_reg[1];
        end
        if (grp_push && fifo_wpos) begin
            fifo_data_reg[1] <= grp_word_reg[0];
            fifo_last_reg[1] <= grp_last_reg && (grp_cnt_reg == 3'd1);
        end
    end

endmodule

### hdl/twrle_checker.sv
// port-level checker for the word run-length encoder and its bind
module twrle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    logic seen_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_in_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            seen_in_reg <= 1'b1;
        end
    end

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

    // no output before any input request
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_in_reg |-> !m_tvalid)
        else $error("output without input");

    // stalled output holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind tagged_word_run_length_encoder twrle_checker u_twrle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
